/* src/scope_edge_trigger_capture_assert.svh */
// assertion macros for the edge trigger capture block
// expects signals named clock and reset in the scope of each use
`ifndef SCOPE_EDGE_TRIGGER_CAPTURE_ASSERT_SVH
`define SCOPE_EDGE_TRIGGER_CAPTURE_ASSERT_SVH

// same-cycle implication, held off during reset
`define SETC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define SETC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/setc_pkg.sv */
// shared types, constants and tables for the edge trigger capture block
// no dependencies
`default_nettype none

package setc_pkg;

   localparam int FRAME_BYTES  = 8;
   localparam int CODE_W       = 8;
   localparam int LANE_W       = 3;
   localparam int COUNT_W      = 4;
   localparam int IDX_W        = 9;
   localparam int MV_W         = 14;
   localparam int FREQ_W       = 24;
   localparam int SEARCH_W     = 10;
   localparam int FRAME_W      = 12;
   localparam int MODE_W       = 4;
   localparam int LEVEL_W      = 8;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [IDX_W-1:0] SHORT_RECORD = IDX_W'(200);
   localparam logic [IDX_W-1:0] LONG_RECORD  = IDX_W'(500);

   // timebase modes that need special handling
   localparam logic [MODE_W-1:0] MODE_DECIM_20 = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_DECIM_10 = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_LONG     = MODE_W'(8);
   localparam logic [MODE_W-1:0] MODE_MAX      = MODE_W'(8);

   // input item codes
   localparam logic OP_ARM   = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   // register indexes on the csr port
   localparam logic [1:0] REG_TRIGGER_LEVEL = 2'd0;
   localparam logic [1:0] REG_MODE          = 2'd1;
   localparam logic [1:0] REG_SEARCH_LIMIT  = 2'd2;

   localparam logic [LEVEL_W-1:0]  RESET_TRIGGER_LEVEL = LEVEL_W'(128);
   localparam logic [MODE_W-1:0]   RESET_MODE          = MODE_W'(2);
   localparam logic [SEARCH_W-1:0] RESET_SEARCH_LIMIT  = SEARCH_W'(120);

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_FREQ   = 2'd1,
      KIND_END    = 2'd2
   } setc_kind_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]  trigger_level;
      logic [MODE_W-1:0]   mode;
      logic [SEARCH_W-1:0] search_limit;
   } setc_cfg_type;

   typedef struct packed {
      logic                                   op;
      logic [FRAME_BYTES-1:0][CODE_W-1:0]     samples;
   } setc_item_type;

   // up to eight results caused by one item
   typedef struct packed {
      logic [COUNT_W-1:0]                     count;
      setc_kind_type                          kind;
      logic [FRAME_BYTES-1:0][CODE_W-1:0]     codes;
      logic [IDX_W-1:0]                       base_index;
      logic [FREQ_W-1:0]                      frequency;
      logic [IDX_W-1:0]                       data_frames;
      logic                                   done;
   } setc_batch_type;

   typedef logic [255:0][MV_W-1:0] setc_mv_table_type;

   // frames per record, counted from the trigger
   function automatic logic [FRAME_W-1:0] frame_cap(input logic [MODE_W-1:0] mode);
      logic [FRAME_W-1:0] cap;
      unique case (mode)
         4'd0:    cap = FRAME_W'(4000);
         4'd1:    cap = FRAME_W'(2000);
         4'd2:    cap = FRAME_W'(200);
         4'd3:    cap = FRAME_W'(25);
         4'd4:    cap = FRAME_W'(51);
         4'd5:    cap = FRAME_W'(200);
         4'd6:    cap = FRAME_W'(25);
         4'd7:    cap = FRAME_W'(51);
         4'd8:    cap = FRAME_W'(500);
         default: cap = '1;
      endcase
      return cap;
   endfunction

   function automatic logic [IDX_W-1:0] record_len(input logic [MODE_W-1:0] mode);
      return (mode == MODE_LONG) ? LONG_RECORD : SHORT_RECORD;
   endfunction

   // millivolts = round(code * 10000 / 255) - 5000, built at elaboration
   // y / 255 done as y * ceil(2^30 / 255) >> 30, exact for y below 5.6e6
   function automatic setc_mv_table_type build_mv_table();
      setc_mv_table_type t;
      longint y;
      longint q;
      for (int c = 0; c < 256; c++) begin
         y    = longint'(c) * 64'sd10000 + 64'sd127;
         q    = (y * 64'sd4210753) >>> 30;
         t[c] = MV_W'(q - 64'sd5000);
      end
      return t;
   endfunction

   localparam setc_mv_table_type MV_TABLE = build_mv_table();

endpackage

`default_nettype wire

/* src/setc_capture_core.sv */
// trigger search and capture state with the per-item result evaluation
// depends on setc_pkg
`default_nettype none

module setc_capture_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire setc_pkg::setc_cfg_type   cfg,
   input  wire setc_pkg::setc_item_type  item,
   input  wire logic                     advance,
   output setc_pkg::setc_batch_type      batch
);
   import setc_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SEARCH,
      PH_CAPTURE,
      PH_DONE
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [SEARCH_W-1:0]   search_count_ff, search_count_in;
   logic [LANE_W-1:0]     trigger_lane_ff, trigger_lane_in;
   logic [FRAME_W-1:0]    frame_count_ff, frame_count_in;
   logic [4:0]            mod20_ff, mod20_in;
   logic [3:0]            mod10_ff, mod10_in;
   logic [IDX_W-1:0]      data_frame_count_ff, data_frame_count_in;
   logic [IDX_W-1:0]      sample_count_ff, sample_count_in;
   logic [FREQ_W-1:0]     frequency_ff, frequency_in;

   logic [FRAME_BYTES-1:1] near_hit;
   logic                   hit;
   logic [LANE_W-1:0]      hit_lane;
   logic [COUNT_W-1:0]     per_count;
   logic [LANE_W-1:0]      lane_step;
   logic [LANE_W-1:0]      emit_start;
   logic [IDX_W-1:0]       rec;
   logic [IDX_W-1:0]       room;
   logic                   head_zero;
   logic                   tail_nz;
   logic                   decim_hit;

   // rising crossing within one code of the level, per lane
   always_comb begin
      for (int i = 1; i < FRAME_BYTES; i++) begin
         near_hit[i] = (((item.samples[i] >= cfg.trigger_level)
                         ? (item.samples[i] - cfg.trigger_level)
                         : (cfg.trigger_level - item.samples[i])) < CODE_W'(2))
                       && (item.samples[i] > item.samples[i-1]);
      end
   end

   // lowest lane wins
   always_comb begin
      hit      = 1'b0;
      hit_lane = '0;
      for (int i = FRAME_BYTES - 1; i >= 1; i--) begin
         if (near_hit[i]) begin
            hit      = 1'b1;
            hit_lane = LANE_W'(i);
         end
      end
   end

   // per-mode lane stride, step 0 stands for a stride of eight
   always_comb begin
      unique case (cfg.mode)
         4'd3, 4'd6: begin
            per_count = COUNT_W'(8);
            lane_step = LANE_W'(1);
         end
         4'd4, 4'd7: begin
            per_count = COUNT_W'(4);
            lane_step = LANE_W'(2);
         end
         default: begin
            per_count = COUNT_W'(1);
            lane_step = '0;
         end
      endcase
   end

   assign rec       = record_len(cfg.mode);
   assign room      = (rec > sample_count_ff) ? (rec - sample_count_ff) : '0;
   assign head_zero = (item.samples[0] | item.samples[1] | item.samples[2]
                       | item.samples[3]) == '0;
   assign tail_nz   = (item.samples[4] | item.samples[5] | item.samples[6]
                       | item.samples[7]) != '0;
   assign decim_hit = (cfg.mode == MODE_DECIM_20) ? (mod20_ff == '0) : (mod10_ff == '0);

   always_comb begin
      phase_in            = phase_ff;
      search_count_in     = search_count_ff;
      trigger_lane_in     = trigger_lane_ff;
      frame_count_in      = frame_count_ff;
      mod20_in            = mod20_ff;
      mod10_in            = mod10_ff;
      data_frame_count_in = data_frame_count_ff;
      sample_count_in     = sample_count_ff;
      frequency_in        = frequency_ff;
      batch.count         = '0;
      batch.kind          = KIND_SAMPLE;
      batch.done          = 1'b0;
      emit_start          = '0;

      if (item.op == OP_ARM) begin
         phase_in            = PH_SEARCH;
         search_count_in     = '0;
         trigger_lane_in     = '0;
         frame_count_in      = '0;
         mod20_in            = '0;
         mod10_in            = '0;
         data_frame_count_in = '0;
         sample_count_in     = '0;
      end else if (cfg.mode <= MODE_MAX && phase_ff == PH_SEARCH) begin
         if (search_count_ff >= cfg.search_limit) begin
            // forced trigger, no samples
            trigger_lane_in = '0;
            frame_count_in  = '0;
            mod20_in        = '0;
            mod10_in        = '0;
            phase_in        = PH_CAPTURE;
         end else if (hit) begin
            trigger_lane_in = hit_lane;
            emit_start      = hit_lane;
            unique case (lane_step)
               LANE_W'(1): batch.count = COUNT_W'(8) - COUNT_W'(hit_lane);
               LANE_W'(2): batch.count = (COUNT_W'(9) - COUNT_W'(hit_lane)) >> 1;
               default:    batch.count = COUNT_W'(1);
            endcase
            sample_count_in = sample_count_ff + IDX_W'(batch.count);
            frame_count_in  = '0;
            mod20_in        = '0;
            mod10_in        = '0;
            phase_in        = PH_CAPTURE;
         end
         if (search_count_ff != '1) begin
            search_count_in = search_count_ff + 1'b1;
         end
      end else if (cfg.mode <= MODE_MAX && phase_ff == PH_CAPTURE) begin
         if (head_zero && (cfg.mode > MODE_DECIM_10 || tail_nz)) begin
            frequency_in = {item.samples[5], item.samples[6], item.samples[7]};
            batch.count  = COUNT_W'(1);
            batch.kind   = KIND_FREQ;
         end else if (cfg.mode <= MODE_DECIM_10) begin
            if (decim_hit && room != '0) begin
               batch.count     = COUNT_W'(1);
               emit_start      = trigger_lane_ff;
               sample_count_in = sample_count_ff + 1'b1;
            end
         end else begin
            batch.count         = (room < IDX_W'(per_count)) ? COUNT_W'(room) : per_count;
            sample_count_in     = sample_count_ff + IDX_W'(batch.count);
            if (data_frame_count_ff != '1) begin
               data_frame_count_in = data_frame_count_ff + 1'b1;
            end
         end
         if (frame_count_ff != '1) begin
            frame_count_in = frame_count_ff + 1'b1;
            mod20_in       = (mod20_ff == 5'd19) ? '0 : mod20_ff + 1'b1;
            mod10_in       = (mod10_ff == 4'd9)  ? '0 : mod10_ff + 1'b1;
         end
         if (sample_count_in >= rec || frame_count_in >= frame_cap(cfg.mode)) begin
            batch.done = 1'b1;
            phase_in   = PH_DONE;
            if (batch.count == '0) begin
               batch.count = COUNT_W'(1);
               batch.kind  = KIND_END;
            end
         end
      end

      // pick the emitted lanes
      for (int k = 0; k < FRAME_BYTES; k++) begin
         batch.codes[k] = item.samples[LANE_W'(emit_start + LANE_W'(k) * lane_step)];
      end
      batch.base_index  = sample_count_ff;
      batch.frequency   = frequency_in;
      batch.data_frames = data_frame_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_IDLE;
         search_count_ff     <= '0;
         trigger_lane_ff     <= '0;
         frame_count_ff      <= '0;
         mod20_ff            <= '0;
         mod10_ff            <= '0;
         data_frame_count_ff <= '0;
         sample_count_ff     <= '0;
         frequency_ff        <= '0;
      end else if (advance) begin
         phase_ff            <= phase_in;
         search_count_ff     <= search_count_in;
         trigger_lane_ff     <= trigger_lane_in;
         frame_count_ff      <= frame_count_in;
         mod20_ff            <= mod20_in;
         mod10_ff            <= mod10_in;
         data_frame_count_ff <= data_frame_count_in;
         sample_count_ff     <= sample_count_in;
         frequency_ff        <= frequency_in;
      end
   end

endmodule

`default_nettype wire

/* src/scope_edge_trigger_capture.sv */
// Edge trigger capture for an oscilloscope front end. An arm transfer starts a
// trigger search; each following frame transfer carries eight converter codes.
// The block finds the first rising crossing of trigger_level (or forces a
// trigger after search_limit frames), then builds a record of millivolt
// samples strided or decimated by mode, with frequency frames reloading a
// 24-bit count. A frame transfer is held in the input register, where its results
// are worked out and the capture state is updated; its results (up to eight) are
// then loaded into the result register and leave one per rsp transfer. Items that
// cause no result pass without waiting for the result register. The next frame is
// taken while results still wait; a frame with results then waits in the input
// register until the result register is free.
// depends on setc_pkg, setc_capture_core and the assertion header
`default_nettype none

`include "scope_edge_trigger_capture_assert.svh"

module scope_edge_trigger_capture (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [63:0]                         req_tdata,  // sample_0 .. sample_7
   input  wire logic [0:0]                          req_tuser,  // op
   // result channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // sample_index, sample_mv, frequency_value, record_done, data_frames, zero fill
   output logic [63:0]                              rsp_tdata,
   output logic [1:0]                               rsp_tuser,  // kind
   output logic                                     rsp_tlast,  // last
   // configuration port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [setc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [setc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [setc_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);
   import setc_pkg::*;

   // configuration registers
   logic [LEVEL_W-1:0]   trigger_level_ff;
   logic [MODE_W-1:0]    mode_ff;
   logic [SEARCH_W-1:0]  search_limit_ff;
   logic                 csr_write;
   setc_cfg_type         cfg;

   // input register
   logic                 in_valid_ff;
   setc_item_type        in_item_ff;

   // result register and its read pointer
   logic                 batch_valid_ff;
   setc_batch_type       batch_ff;
   logic [LANE_W-1:0]    ptr_ff;

   setc_batch_type       eval;
   logic                 advance;
   logic                 load;
   logic                 rsp_xfer;
   logic                 last_now;
   logic                 batch_free;
   logic [CODE_W-1:0]    cur_code;
   logic [IDX_W-1:0]     cur_index;
   logic [MV_W-1:0]      cur_mv;
   logic                 cur_done;

   // ---- configuration port ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_TRIGGER_LEVEL: csr_prdata = CSR_DATA_W'(trigger_level_ff);
         REG_MODE:          csr_prdata = CSR_DATA_W'(mode_ff);
         REG_SEARCH_LIMIT:  csr_prdata = CSR_DATA_W'(search_limit_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // trigger_level, mode, search_limit from the top bit down
   assign cfg = {trigger_level_ff, mode_ff, search_limit_ff};

   // ---- evaluation of the held item ----
   setc_capture_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (in_item_ff),
      .advance (advance),
      .batch   (eval)
   );

   // ---- handshakes ----
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign last_now   = (COUNT_W'(ptr_ff) + 1'b1) == batch_ff.count;
   assign batch_free = !batch_valid_ff || (rsp_xfer && last_now);
   // items without results never wait for the result register
   assign advance    = in_valid_ff && ((eval.count == '0) || batch_free);
   assign load       = advance && (eval.count != '0);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_level_ff <= RESET_TRIGGER_LEVEL;
         mode_ff          <= RESET_MODE;
         search_limit_ff  <= RESET_SEARCH_LIMIT;
         in_valid_ff      <= 1'b0;
         batch_valid_ff   <= 1'b0;
         ptr_ff           <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_paddr[3:2])
               REG_TRIGGER_LEVEL: trigger_level_ff <= csr_pwdata[LEVEL_W-1:0];
               REG_MODE:          mode_ff          <= csr_pwdata[MODE_W-1:0];
               REG_SEARCH_LIMIT:  search_limit_ff  <= csr_pwdata[SEARCH_W-1:0];
               default:           ;
            endcase
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (load) begin
            batch_valid_ff <= 1'b1;
            ptr_ff         <= '0;
         end else if (rsp_xfer) begin
            if (last_now) begin
               batch_valid_ff <= 1'b0;
            end else begin
               ptr_ff <= ptr_ff + 1'b1;
            end
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.op      <= req_tuser[0];
         in_item_ff.samples <= req_tdata;
      end
      if (load) begin
         batch_ff <= eval;
      end
   end

   // ---- result fields ----
   assign cur_code  = batch_ff.codes[ptr_ff];
   assign cur_index = (batch_ff.kind == KIND_SAMPLE)
                      ? (batch_ff.base_index + IDX_W'(ptr_ff)) : '0;
   assign cur_mv    = (batch_ff.kind == KIND_SAMPLE) ? MV_TABLE[cur_code] : '0;
   assign cur_done  = batch_ff.done && last_now;

   assign rsp_tvalid = batch_valid_ff;
   assign rsp_tuser  = batch_ff.kind;
   assign rsp_tlast  = last_now;
   assign rsp_tdata  = {7'd0, batch_ff.data_frames, cur_done, batch_ff.frequency,
                        cur_mv, cur_index};

   // ---- assertions ----
   // pointer never walks past the results held
   `SETC_ASSERT_NOW(a_ptr_in_batch, batch_valid_ff, (batch_ff.count != '0) && (COUNT_W'(ptr_ff) < batch_ff.count), "result pointer outside the held results")
   // frequency and record end results stand alone
   `SETC_ASSERT_NOW(a_single_kind, batch_valid_ff && (batch_ff.kind != KIND_SAMPLE), batch_ff.count == COUNT_W'(1), "non-sample result not alone in its item")
   // record end marked only on the final result of an item
   `SETC_ASSERT_NOW(a_done_on_last, rsp_tvalid && rsp_tdata[47], rsp_tlast, "record end before the last result")
   // a drained result register empties unless refilled
   `SETC_ASSERT_NEXT(a_drain_empties, rsp_xfer && last_now && !load, !batch_valid_ff, "result register still valid after its last transfer")

endmodule

`default_nettype wire
